// ===== hdl/epmr_pkg.sv =====
// ----------------------------------------------------------------------------
// epmr_pkg: shared types and constants for the echo pulse median ranger
// Field widths, the median window size and the fixed-point constants used to
// turn an echo pulse width in microseconds into centimeters.
// ----------------------------------------------------------------------------
`default_nettype none

package epmr_pkg;

  // Field widths
  localparam int CAP_W   = 16;  // timer capture, 1 us ticks
  localparam int DIST_W  = 11;  // computed distance, cm
  localparam int RING_W  = 7;   // stored distance, cm
  localparam int LIMIT_W = 7;   // distance limit register

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd75;

  // Median window
  localparam int WINDOW = 5;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int RANK_W = $clog2(WINDOW);
  localparam int MID    = WINDOW / 2;

  // floor(diff * 17 / 1000) == (diff * RECIP) >> RECIP_SHIFT for any 16-bit
  // diff: RECIP = ceil(17 * 2^26 / 1000), rounding error 0.312 / 2^26 per tick.
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1140851;
  localparam int PROD_W      = CAP_W + RECIP_W;

  // Per-pulse result passed from the range stage to the ring stage
  typedef struct packed {
    logic              done;  // falling capture closed a pulse
    logic [DIST_W-1:0] raw;   // distance computed or kept, 0 on rising
  } pulse_t;

endpackage

`default_nettype wire

// ===== hdl/epmr_range.sv =====
// ----------------------------------------------------------------------------
// epmr_range: echo edge tracking and pulse width to distance conversion
// Keeps the rising capture and last distance; on a falling capture converts
// the tick difference, if positive, to centimeters by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module epmr_range (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic [epmr_pkg::CAP_W-1:0] cap,
  output epmr_pkg::pulse_t               pulse
);

  logic                          awaiting_fall;
  logic [epmr_pkg::CAP_W-1:0]    rise_count;
  logic [epmr_pkg::DIST_W-1:0]   last_distance;

  logic [epmr_pkg::CAP_W-1:0]    diff;
  logic [epmr_pkg::PROD_W-1:0]   prod;
  logic [epmr_pkg::DIST_W-1:0]   distance_next;

  // Width to distance: diff * 17 / 1000 via scaled reciprocal
  always_comb begin
    diff = cap - rise_count;
    prod = epmr_pkg::PROD_W'(diff) * epmr_pkg::PROD_W'(epmr_pkg::RECIP);
    distance_next = (cap > rise_count)
                  ? prod[epmr_pkg::RECIP_SHIFT +: epmr_pkg::DIST_W]
                  : last_distance;
  end

  // Result for this capture; rising captures report zero
  always_comb begin
    pulse.done = awaiting_fall;
    pulse.raw  = awaiting_fall ? distance_next : '0;
  end

  // Edge state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_fall <= 1'b0;
      rise_count    <= '0;
      last_distance <= '0;
    end else if (take) begin
      awaiting_fall <= ~awaiting_fall;
      if (!awaiting_fall) begin
        rise_count <= cap;
      end else begin
        last_distance <= distance_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/epmr_ring.sv =====
// ----------------------------------------------------------------------------
// epmr_ring: limit check, distance ring store and median network
// Stores accepted distances round robin and reports the median of the ring
// through a parallel rank count.
// ----------------------------------------------------------------------------
`default_nettype none

module epmr_ring (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         take,
  input  wire epmr_pkg::pulse_t             pulse,
  input  wire logic [epmr_pkg::LIMIT_W-1:0] limit,
  output logic                              accept,
  output logic [epmr_pkg::RING_W-1:0]       median
);

  logic [epmr_pkg::RING_W-1:0] ring [epmr_pkg::WINDOW];
  logic [epmr_pkg::SLOT_W-1:0] write_slot;
  logic [epmr_pkg::RANK_W-1:0] rank [epmr_pkg::WINDOW];

  // Limit check on falling captures only
  assign accept = pulse.done &&
                  (pulse.raw < epmr_pkg::DIST_W'(limit));

  // Ring write, slot wraps at the window size
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      for (int i = 0; i < epmr_pkg::WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else if (take && accept) begin
      ring[write_slot] <= pulse.raw[epmr_pkg::RING_W-1:0];
      if (write_slot == epmr_pkg::SLOT_W'(epmr_pkg::WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + epmr_pkg::SLOT_W'(1);
      end
    end
  end

  // Rank of each entry: smaller values, ties broken by position
  always_comb begin
    for (int i = 0; i < epmr_pkg::WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < epmr_pkg::WINDOW; j++) begin
        if ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i))) begin
          rank[i] = rank[i] + epmr_pkg::RANK_W'(1);
        end
      end
    end
  end

  // Exactly one entry holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < epmr_pkg::WINDOW; i++) begin
      if (rank[i] == epmr_pkg::RANK_W'(epmr_pkg::MID)) begin
        median = ring[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/echo_pulse_median_ranger_core.sv =====
// ----------------------------------------------------------------------------
// echo_pulse_median_ranger_core: echo timer captures to median distance
// Pairs rising/falling echo captures into distances in cm, filters them
// against a limit and reports the median of the last accepted distances.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  capture   in         capture_valid/_stall   capture_value
//  result    out        result_valid/_stall    pulse_done, raw_distance,
//                                              accepted, median_distance
//  limit     in         limit_valid/_ready     distance_limit
//
//  Four register stages (input, range, ring write, output): a transaction
//  passes through them in that order, one per cycle sustained while
//  result_stall is low. Each stage advances when the next one is empty or
//  moving, so bubbles collapse and a stalled result does not block stages
//  behind it until they fill. rst is synchronous; limit returns to 75 cm
//  and the ring to all zero. limit writes are always taken.
//
`default_nettype none

module echo_pulse_median_ranger_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // capture channel
  input  wire logic                         capture_valid,
  output logic                              capture_stall,
  input  wire logic [epmr_pkg::CAP_W-1:0]   capture_value,
  // result channel
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic                              pulse_done,
  output logic [epmr_pkg::DIST_W-1:0]       raw_distance,
  output logic                              accepted,
  output logic [epmr_pkg::RING_W-1:0]       median_distance,
  // limit register write
  input  wire logic                         limit_valid,
  output logic                              limit_ready,
  input  wire logic [epmr_pkg::LIMIT_W-1:0] distance_limit
);

  logic [epmr_pkg::LIMIT_W-1:0] limit;

  // Stage registers
  logic                         a_valid;
  logic [epmr_pkg::CAP_W-1:0]   a_cap;
  logic                         b_valid;
  epmr_pkg::pulse_t             b_pulse;
  logic                         c_valid;
  epmr_pkg::pulse_t             c_pulse;
  logic                         c_acc;

  logic                         ready_a, ready_b, ready_c, ready_d;
  logic                         move_ab, move_bc, move_cd;
  epmr_pkg::pulse_t             range_pulse;
  logic                         ring_accept;
  logic [epmr_pkg::RING_W-1:0]  ring_median;

  // Stage flow control
  always_comb begin
    ready_d = !result_valid || !result_stall;
    ready_c = !c_valid || ready_d;
    ready_b = !b_valid || ready_c;
    ready_a = !a_valid || ready_b;
    move_ab = a_valid && ready_b;
    move_bc = b_valid && ready_c;
    move_cd = c_valid && ready_d;
  end

  assign capture_stall = !ready_a;

  // Limit register
  assign limit_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= epmr_pkg::LIMIT_RESET;
    end else if (limit_valid && limit_ready) begin
      limit <= distance_limit;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= capture_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && capture_valid) begin
      a_cap <= capture_value;
    end
  end

  // Range stage
  epmr_range u_range (
    .clk   (clk),
    .rst   (rst),
    .take  (move_ab),
    .cap   (a_cap),
    .pulse (range_pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_pulse <= range_pulse;
    end
  end

  // Ring stage
  epmr_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .take   (move_bc),
    .pulse  (b_pulse),
    .limit  (limit),
    .accept (ring_accept),
    .median (ring_median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (ready_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_bc) begin
      c_pulse <= b_pulse;
      c_acc   <= ring_accept;
    end
  end

  // Output register; ring already holds this transaction's write
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready_d) begin
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_cd) begin
      pulse_done      <= c_pulse.done;
      raw_distance    <= c_pulse.raw;
      accepted        <= c_acc;
      median_distance <= ring_median;
    end
  end

endmodule

`default_nettype wire
